// ----- rtl/dsm_pkg.sv -----
package dsm_pkg;

  // Door phases. The eighth code cannot be reached and is handled as boot.
  typedef enum logic [2:0] {
    PH_BOOT        = 3'd0,
    PH_OPEN        = 3'd1,
    PH_PART_OPEN   = 3'd2,
    PH_CLOSED      = 3'd3,
    PH_PART_CLOSED = 3'd4,
    PH_HELD        = 3'd5,
    PH_PART_HELD   = 3'd6
  } phase_e;

  // Door programs selected by the mode register.
  localparam logic [2:0] MODE_DISABLED    = 3'd0;
  localparam logic [2:0] MODE_SINGLE_GND  = 3'd1;
  localparam logic [2:0] MODE_SINGLE_HIGH = 3'd2;
  localparam logic [2:0] MODE_DUAL_GND    = 3'd3;
  localparam logic [2:0] MODE_DUAL_HIGH   = 3'd4;
  localparam logic [2:0] MODE_LOCK_GND    = 3'd5;
  localparam logic [2:0] MODE_LOCK_HIGH   = 3'd6;
  localparam logic [2:0] MODE_UNUSED      = 3'd7;

  // Relay roles.
  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_CUTOFF = 2'd1;
  localparam logic [1:0] ROLE_CLOSED = 2'd2;
  localparam logic [1:0] ROLE_LOCKED = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_DOOR_MODE   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD   = 3'd1;
  localparam logic [2:0] REG_HOLD_TICKS  = 3'd2;
  localparam logic [2:0] REG_RELAY0_ROLE = 3'd3;
  localparam logic [2:0] REG_RELAY1_ROLE = 3'd4;
  localparam logic [2:0] REG_RELAY2_ROLE = 3'd5;
  localparam logic [2:0] REG_RELAY3_ROLE = 3'd6;

  localparam int unsigned NumRelays = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [9:0]  ThresholdReset = 10'd128;
  localparam logic [15:0] HoldTicksReset = 16'd220;
  localparam logic [15:0] TickMax        = 16'hFFFF;

  typedef struct packed {
    logic [9:0] sense_a;
    logic [9:0] sense_b;
    logic       believed_locked;
    logic       motion_sensed;
  } dsm_in_t;

  typedef struct packed {
    logic [2:0] door_state;
    logic       state_changed;
    logic       doors_closed;
    logic       doors_open;
    logic       doors_partly_open;
    logic       door_locked;
    logic       allow_locking;
    logic       motion_cutoff;
    logic [3:0] relay_drive;
    logic [3:0] relay_active;
  } dsm_out_t;

endpackage

// ----- rtl/door_state_monitor.sv -----
// Door state monitor.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one sample item:
// two sense converter readings, the believed-locked flag and the motion input.
// Output channel (out_valid_o / out_ready_i / out_data_o) carries one result
// item per sample while the door mode is neither disabled nor the unused code; in
// those modes an item is consumed and produces nothing, and the door state is left untouched.
// Configuration is a write-only port (cfg_we_i, cfg_index_i, cfg_data_i) that the user
// must write only while no item is in flight; the block itself does not enforce it.
// Structure: a sample accepted at a clock edge is held in the input register,
// and its result is loaded into the output register when that register has room.
// Throughput is one item per cycle while the receiver takes results;
// the classification, the door machine and the relay logic are a single level
// of logic between the input register and the output register.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more sample; ready drops only when both are full.
// Reset clears both registers' valid flags, returns the door machine to boot
// with a zero hold timer and loads the configuration registers with their default values.
module door_state_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dsm_pkg::dsm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dsm_pkg::dsm_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dsm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dsm_pkg::*;

  // Configuration registers.
  logic [2:0]                     door_mode_q;
  logic [9:0]                     threshold_q;
  logic [15:0]                    hold_ticks_q;
  logic [NumRelays-1:0][1:0]      relay_role_q;

  // Door machine state.
  phase_e      phase_q, phase_d;
  logic [15:0] ticks_q, ticks_d;

  // Input and output registers.
  logic     s1_valid_q;
  dsm_in_t  s1_data_q;
  logic     out_valid_q;
  dsm_out_t out_q;
  dsm_out_t res;

  logic mode_enabled;
  logic out_space;
  logic s1_leave;
  logic out_load;
  logic a_gnd, b_gnd, a_closed, b_closed, locked;
  logic closed, open_both, partly;
  logic [15:0] elapsed;
  logic hold_done;
  logic allow, cutoff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_mode_q  <= MODE_DISABLED;
      threshold_q  <= ThresholdReset;
      hold_ticks_q <= HoldTicksReset;
      relay_role_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DOOR_MODE:   door_mode_q     <= cfg_data_i[2:0];
        REG_THRESHOLD:   threshold_q     <= cfg_data_i[9:0];
        REG_HOLD_TICKS:  hold_ticks_q    <= cfg_data_i[15:0];
        REG_RELAY0_ROLE: relay_role_q[0] <= cfg_data_i[1:0];
        REG_RELAY1_ROLE: relay_role_q[1] <= cfg_data_i[1:0];
        REG_RELAY2_ROLE: relay_role_q[2] <= cfg_data_i[1:0];
        REG_RELAY3_ROLE: relay_role_q[3] <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign mode_enabled = (door_mode_q != MODE_DISABLED) && (door_mode_q != MODE_UNUSED);
  assign out_space    = !out_valid_q || out_ready_i;
  // A disabled-mode item leaves without needing room in the output register.
  assign s1_leave     = s1_valid_q && (!mode_enabled || out_space);
  assign out_load     = s1_valid_q && mode_enabled && out_space;
  assign in_ready_o   = !s1_valid_q || s1_leave;

  // Leaf classification.
  always_comb begin
    a_gnd = s1_data_q.sense_a < threshold_q;
    b_gnd = s1_data_q.sense_b < threshold_q;
    a_closed = a_gnd;
    b_closed = a_gnd;
    locked   = s1_data_q.believed_locked;
    unique case (door_mode_q)
      MODE_SINGLE_GND: begin
        a_closed = a_gnd;
        b_closed = a_gnd;
      end
      MODE_SINGLE_HIGH: begin
        a_closed = !a_gnd;
        b_closed = !a_gnd;
      end
      MODE_DUAL_GND: begin
        a_closed = a_gnd;
        b_closed = b_gnd;
      end
      MODE_DUAL_HIGH: begin
        a_closed = !a_gnd;
        b_closed = !b_gnd;
      end
      MODE_LOCK_GND: begin
        a_closed = a_gnd;
        b_closed = a_gnd;
        locked   = b_gnd;
      end
      MODE_LOCK_HIGH: begin
        a_closed = !a_gnd;
        b_closed = !a_gnd;
        locked   = !b_gnd;
      end
      default: ;
    endcase
    closed    = a_closed && b_closed;
    open_both = !a_closed && !b_closed;
    partly    = a_closed != b_closed;
  end

  assign elapsed   = (ticks_q != TickMax) ? ticks_q + 16'd1 : TickMax;
  assign hold_done = elapsed >= hold_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BOOT;
      ticks_q <= '0;
    end else if (out_load) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_OPEN: begin
        if (partly)      phase_d = PH_PART_OPEN;
        else if (closed) phase_d = PH_CLOSED;
      end
      PH_PART_OPEN, PH_PART_CLOSED: begin
        if (open_both)   phase_d = PH_OPEN;
        else if (closed) phase_d = PH_CLOSED;
      end
      PH_CLOSED: begin
        if (partly)         phase_d = PH_PART_CLOSED;
        else if (open_both) phase_d = PH_OPEN;
        else if (hold_done) phase_d = PH_HELD;
      end
      PH_HELD: begin
        if (partly)         phase_d = PH_PART_HELD;
        else if (open_both) phase_d = PH_OPEN;
      end
      PH_PART_HELD: begin
        if (closed)         phase_d = PH_HELD;
        else if (open_both) phase_d = PH_OPEN;
        else if (hold_done) phase_d = PH_PART_CLOSED;
      end
      default: begin
        if (closed)         phase_d = PH_CLOSED;
        else if (open_both) phase_d = PH_OPEN;
        else                phase_d = PH_PART_OPEN;
      end
    endcase
    ticks_d = (phase_d != phase_q) ? '0 : elapsed;
  end

  assign allow  = !(phase_d == PH_OPEN || phase_d == PH_PART_OPEN ||
                    phase_d == PH_PART_CLOSED);
  assign cutoff = (phase_d == PH_HELD || phase_d == PH_PART_HELD) &&
                  s1_data_q.motion_sensed;

  always_comb begin
    res.door_state        = phase_d;
    res.state_changed     = phase_d != phase_q;
    res.doors_closed      = closed;
    res.doors_open        = open_both;
    res.doors_partly_open = partly;
    res.door_locked       = locked;
    res.allow_locking     = allow;
    res.motion_cutoff     = cutoff;
    for (int i = 0; i < NumRelays; i++) begin
      res.relay_active[i] = relay_role_q[i] != ROLE_NONE;
      case (relay_role_q[i])
        ROLE_CUTOFF: res.relay_drive[i] = cutoff || !allow;
        ROLE_CLOSED: res.relay_drive[i] = closed;
        ROLE_LOCKED: res.relay_drive[i] = locked;
        default:     res.relay_drive[i] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_space) begin
        out_valid_q <= out_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ticks_clear_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res.state_changed) |=> (ticks_q == '0))
    else $error("hold timer not cleared on a door state change");

  a_no_result_when_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> mode_enabled)
    else $error("result produced in disabled mode");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i && mode_enabled))
    else $error("input stalled while there is room");

  a_cutoff_allows_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.motion_cutoff) |-> out_q.allow_locking)
    else $error("motion cutoff outside a held state");

endmodule

// ----- sim/door_state_monitor_tb.sv -----
`timescale 1ns / 100ps

module door_state_monitor_tb;
  import dsm_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 4;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  dsm_in_t    in_data_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  dsm_out_t   out_data_o;
  logic       cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow copy of the registers and of the door machine.
  logic [2:0]  mode_q      = MODE_DISABLED;
  logic [9:0]  threshold_q = ThresholdReset;
  logic [15:0] hold_q      = HoldTicksReset;
  logic [1:0]  role_q [NumRelays];
  phase_e      phase_q     = PH_BOOT;
  logic [15:0] ticks_q     = '0;

  dsm_out_t    door_reports_due [$];
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned hold_off_req  = 0;
  bit          tx_idle       = 1'b0;
  bit          rx_idle       = 1'b0;

  door_state_monitor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NumRelays; i++) begin
      role_q[i] = ROLE_NONE;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CycleLimit) begin
        $display("door_state_monitor test failed");
        $finish;
      end
    end
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 19) < 16) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Works out the report of one sample and, in an enabled mode, advances the shadow door machine.
  function automatic bit next_door_report(input dsm_in_t s, output dsm_out_t r);
    bit a_gnd, b_gnd, a_cl, b_cl, locked;
    bit closed, open, partly, allow, cutoff, changed, lvl;
    logic [15:0] elapsed;
    phase_e nxt;
    r = '0;
    if (mode_q == MODE_DISABLED || mode_q == MODE_UNUSED) begin
      return 1'b0;
    end
    a_gnd = s.sense_a < threshold_q;
    b_gnd = s.sense_b < threshold_q;
    case (mode_q)
      MODE_SINGLE_GND: begin
        a_cl = a_gnd; b_cl = a_cl; locked = s.believed_locked;
      end
      MODE_SINGLE_HIGH: begin
        a_cl = !a_gnd; b_cl = a_cl; locked = s.believed_locked;
      end
      MODE_DUAL_GND: begin
        a_cl = a_gnd; b_cl = b_gnd; locked = s.believed_locked;
      end
      MODE_DUAL_HIGH: begin
        a_cl = !a_gnd; b_cl = !b_gnd; locked = s.believed_locked;
      end
      MODE_LOCK_GND: begin
        a_cl = a_gnd; b_cl = a_cl; locked = b_gnd;
      end
      default: begin
        a_cl = !a_gnd; b_cl = a_cl; locked = !b_gnd;
      end
    endcase
    closed = a_cl && b_cl;
    open   = !a_cl && !b_cl;
    partly = a_cl != b_cl;

    elapsed = (ticks_q == TickMax) ? TickMax : ticks_q + 16'd1;
    nxt = phase_q;
    case (phase_q)
      PH_OPEN: begin
        if (partly) nxt = PH_PART_OPEN;
        else if (closed) nxt = PH_CLOSED;
      end
      PH_PART_OPEN, PH_PART_CLOSED: begin
        if (open) nxt = PH_OPEN;
        else if (closed) nxt = PH_CLOSED;
      end
      PH_CLOSED: begin
        if (partly) nxt = PH_PART_CLOSED;
        else if (open) nxt = PH_OPEN;
        else if (elapsed >= hold_q) nxt = PH_HELD;
      end
      PH_HELD: begin
        if (partly) nxt = PH_PART_HELD;
        else if (open) nxt = PH_OPEN;
      end
      PH_PART_HELD: begin
        if (closed) nxt = PH_HELD;
        else if (open) nxt = PH_OPEN;
        else if (elapsed >= hold_q) nxt = PH_PART_CLOSED;
      end
      default: begin
        if (closed) nxt = PH_CLOSED;
        else if (open) nxt = PH_OPEN;
        else nxt = PH_PART_OPEN;
      end
    endcase
    changed = nxt != phase_q;
    phase_q = nxt;
    ticks_q = changed ? 16'd0 : elapsed;

    allow  = !(nxt == PH_OPEN || nxt == PH_PART_OPEN || nxt == PH_PART_CLOSED);
    cutoff = (nxt == PH_HELD || nxt == PH_PART_HELD) && s.motion_sensed;

    for (int i = 0; i < NumRelays; i++) begin
      case (role_q[i])
        ROLE_CUTOFF: lvl = cutoff || !allow;
        ROLE_CLOSED: lvl = closed;
        ROLE_LOCKED: lvl = locked;
        default:     lvl = 1'b0;
      endcase
      r.relay_active[i] = role_q[i] != ROLE_NONE;
      r.relay_drive[i]  = lvl;
    end
    r.door_state        = nxt;
    r.state_changed     = changed;
    r.doors_closed      = closed;
    r.doors_open        = open;
    r.doors_partly_open = partly;
    r.door_locked       = locked;
    r.allow_locking     = allow;
    r.motion_cutoff     = cutoff;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (want !== got) begin
      fail_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Result side: compares each accepted item with the oldest prediction.
  always @(posedge clk_i) begin
    dsm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (door_reports_due.size() == 0) begin
        fail_cnt++;
        $error("door report with no sample waiting: %h", out_data_o);
      end else begin
        want = door_reports_due.pop_front();
        check_field("door_state", 4'(want.door_state), 4'(out_data_o.door_state));
        check_field("state_changed", 4'(want.state_changed),
                    4'(out_data_o.state_changed));
        check_field("doors_closed", 4'(want.doors_closed), 4'(out_data_o.doors_closed));
        check_field("doors_open", 4'(want.doors_open), 4'(out_data_o.doors_open));
        check_field("doors_partly_open", 4'(want.doors_partly_open),
                    4'(out_data_o.doors_partly_open));
        check_field("door_locked", 4'(want.door_locked), 4'(out_data_o.door_locked));
        check_field("allow_locking", 4'(want.allow_locking),
                    4'(out_data_o.allow_locking));
        check_field("motion_cutoff", 4'(want.motion_cutoff),
                    4'(out_data_o.motion_cutoff));
        check_field("relay_drive", want.relay_drive, out_data_o.relay_drive);
        check_field("relay_active", want.relay_active, out_data_o.relay_active);
      end
    end
  end

  // Receiver: a requested hold-off first, then random stalls when enabled.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        n = hold_off_req;
        hold_off_req = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      if (rx_idle && $urandom_range(0, 3) == 0) begin
        n = idle_len();
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Offers one sample, holds it until accepted, then records its report.
  task automatic send_sample(input dsm_in_t s);
    int unsigned gap;
    dsm_out_t r;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (next_door_report(s, r)) begin
      door_reports_due.push_back(r);
    end
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (door_reports_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_DOOR_MODE:  mode_q      = val[2:0];
      REG_THRESHOLD:  threshold_q = val[9:0];
      REG_HOLD_TICKS: hold_q      = val;
      REG_RELAY0_ROLE, REG_RELAY1_ROLE, REG_RELAY2_ROLE, REG_RELAY3_ROLE:
        role_q[idx - REG_RELAY0_ROLE] = val[1:0];
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_roles(input logic [1:0] r0, input logic [1:0] r1,
                             input logic [1:0] r2, input logic [1:0] r3);
    write_reg(REG_RELAY0_ROLE, 16'(r0));
    write_reg(REG_RELAY1_ROLE, 16'(r1));
    write_reg(REG_RELAY2_ROLE, 16'(r2));
    write_reg(REG_RELAY3_ROLE, 16'(r3));
  endtask

  function automatic dsm_in_t sample_of(input int unsigned a, input int unsigned b,
                                        input bit believed, input bit motion);
    dsm_in_t s;
    s.sense_a         = 10'(a);
    s.sense_b         = 10'(b);
    s.believed_locked = believed;
    s.motion_sensed   = motion;
    return s;
  endfunction

  // A converter reading on the wanted side of the threshold, often right at it.
  function automatic logic [9:0] reading(input bit gnd);
    if (gnd && threshold_q != 0) begin
      if ($urandom_range(0, 3) == 0) return threshold_q - 10'd1;
      return 10'($urandom_range(int'(threshold_q) - 1, 0));
    end
    if (!gnd) begin
      if ($urandom_range(0, 3) == 0) return threshold_q;
      return 10'($urandom_range(1023, int'(threshold_q)));
    end
    return 10'($urandom_range(1023, 0));
  endfunction

  // Builds a sample that the current program reads as the wanted leaf states.
  function automatic dsm_in_t door_sample(input bit a_cl, input bit b_cl, input bit locked);
    dsm_in_t s;
    bit high;
    high = mode_q == MODE_SINGLE_HIGH || mode_q == MODE_DUAL_HIGH ||
           mode_q == MODE_LOCK_HIGH;
    s.sense_a         = reading(a_cl ^ high);
    s.sense_b         = 10'($urandom_range(1023, 0));
    s.believed_locked = locked;
    s.motion_sensed   = 1'($urandom_range(0, 1));
    case (mode_q)
      MODE_DUAL_GND, MODE_DUAL_HIGH: s.sense_b = reading(b_cl ^ high);
      MODE_LOCK_GND, MODE_LOCK_HIGH: begin
        s.sense_b         = reading(locked ^ high);
        s.believed_locked = 1'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic test_reset_and_disabled();
    // Defaults after reset: disabled, threshold 128, hold 220, no relay roles.
    send_sample(sample_of(0, 0, 1, 1));
    send_sample(sample_of(1023, 1023, 0, 0));
    wait_for_drain();
    write_reg(REG_DOOR_MODE, 16'(MODE_UNUSED));
    send_sample(sample_of(5, 5, 1, 1));
    wait_for_drain();
    write_reg(REG_DOOR_MODE, 16'(MODE_SINGLE_GND));
    send_sample(sample_of(127, 1023, 0, 1));
    send_sample(sample_of(128, 0, 1, 0));
    send_sample(sample_of(0, 512, 1, 1));
    send_sample(sample_of(1023, 1023, 0, 0));
  endtask

  task automatic test_door_programs();
    wait_for_drain();
    write_roles(ROLE_CUTOFF, ROLE_CLOSED, ROLE_LOCKED, ROLE_NONE);
    write_reg(REG_THRESHOLD, 16'd512);
    for (logic [2:0] m = MODE_SINGLE_HIGH; m <= MODE_LOCK_HIGH; m++) begin
      wait_for_drain();
      write_reg(REG_DOOR_MODE, 16'(m));
      send_sample(sample_of(0, 1023, 1, 0));
      send_sample(sample_of(1023, 0, 0, 1));
    end
    // Threshold extremes: nothing is grounded at 0, only 1023 stays high at 1023.
    wait_for_drain();
    write_reg(REG_DOOR_MODE, 16'(MODE_SINGLE_GND));
    write_reg(REG_THRESHOLD, 16'd0);
    send_sample(sample_of(0, 0, 0, 1));
    wait_for_drain();
    write_reg(REG_THRESHOLD, 16'd1023);
    send_sample(sample_of(1022, 1023, 1, 0));
  endtask

  task automatic test_hold_timing();
    wait_for_drain();
    write_reg(REG_DOOR_MODE, 16'(MODE_DUAL_GND));
    write_reg(REG_THRESHOLD, 16'(ThresholdReset));
    write_reg(REG_HOLD_TICKS, 16'd1);
    write_roles(ROLE_LOCKED, ROLE_CUTOFF, ROLE_CLOSED, ROLE_CUTOFF);
    send_sample(sample_of(1023, 1023, 0, 0));
    send_sample(sample_of(0, 0, 1, 0));
    send_sample(sample_of(0, 0, 1, 1));
    send_sample(sample_of(0, 1023, 1, 1));
    send_sample(sample_of(1023, 0, 0, 1));
    send_sample(sample_of(0, 0, 1, 0));
    send_sample(sample_of(0, 0, 0, 1));
    // A hold time of zero must behave as one tick.
    wait_for_drain();
    write_reg(REG_HOLD_TICKS, 16'd0);
    send_sample(sample_of(0, 1023, 0, 1));
    send_sample(sample_of(0, 1023, 1, 1));
    send_sample(sample_of(0, 0, 1, 0));
    send_sample(sample_of(0, 0, 1, 1));
  endtask

  task automatic test_output_stall();
    wait_for_drain();
    write_reg(REG_HOLD_TICKS, 16'd2);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_off_req = 50;
    for (int i = 0; i < 10; i++) begin
      send_sample(door_sample(i > 3, i > 5, i[0]));
    end
    // Pause the sender until every report is back, then resume.
    wait_for_drain();
    for (int i = 0; i < 5; i++) begin
      send_sample(door_sample(1'b1, i != 2, 1'b1));
    end
  endtask

  task automatic test_random_doors(input int unsigned chunks, input int unsigned per_chunk);
    int unsigned sel, n;
    bit a_cl, b_cl, dual;
    for (int unsigned c = 0; c < chunks; c++) begin
      wait_for_drain();
      write_reg(REG_DOOR_MODE, ($urandom_range(0, 9) == 0) ? 16'(MODE_DISABLED) :
                16'($urandom_range(int'(MODE_LOCK_HIGH), int'(MODE_SINGLE_GND))));
      sel = $urandom_range(0, 5);
      write_reg(REG_THRESHOLD, (sel == 0) ? 16'd0 : (sel == 1) ? 16'd1023 :
                16'($urandom_range(1023, 0)));
      sel = $urandom_range(0, 7);
      write_reg(REG_HOLD_TICKS, (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                16'($urandom_range(6, 1)));
      write_roles(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      dual = mode_q == MODE_DUAL_GND || mode_q == MODE_DUAL_HIGH;
      // Disabled stretches are kept short since they produce nothing.
      n = (mode_q == MODE_DISABLED) ? 5 : per_chunk;
      a_cl = 1'($urandom_range(0, 1));
      b_cl = a_cl;
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          a_cl = 1'($urandom_range(0, 1));
          b_cl = (dual && $urandom_range(0, 2) == 0) ? !a_cl : a_cl;
        end
        if ($urandom_range(0, 7) == 0) begin
          send_sample(dsm_in_t'($urandom));
        end else begin
          send_sample(door_sample(a_cl, b_cl, 1'($urandom_range(0, 1))));
        end
      end
    end
  endtask

  // Long hold time: the door becomes held only after the full count of closed samples.
  task automatic test_hold_limit();
    wait_for_drain();
    write_reg(REG_DOOR_MODE, 16'(MODE_SINGLE_GND));
    write_reg(REG_THRESHOLD, 16'(ThresholdReset));
    write_reg(REG_HOLD_TICKS, 16'd25);
    write_roles(ROLE_CUTOFF, ROLE_CLOSED, ROLE_LOCKED, ROLE_CUTOFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_sample(sample_of(1023, 0, 0, 1));
    for (int unsigned i = 0; i < 30; i++) begin
      send_sample(sample_of(0, 0, 1, i > 22));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_disabled();
    test_door_programs();
    test_hold_timing();
    test_output_stall();
    test_random_doors(10, 38);
    test_hold_limit();

    in_valid_i <= 1'b0;
    for (int i = 0; i < 2000 && door_reports_due.size() != 0; i++) begin
      @(posedge clk_i);
    end
    if (door_reports_due.size() != 0) begin
      fail_cnt++;
      $error("%0d door reports never arrived", door_reports_due.size());
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("door_state_monitor test passed");
    end else begin
      $display("door_state_monitor test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dsm_pkg.sv
rtl/door_state_monitor.sv
sim/door_state_monitor_tb.sv
